### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Condition never holds.
`define ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed");

`endif

### rtl/pjb_pkg.sv
// ============================================================================
// pjb_pkg: shared types and constants of the packet jitter buffer
// Word formats, register indexes, reset values.
// ============================================================================
`timescale 1ns / 1ps

package pjb_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam logic [8:0]  ATT_RST = 9'd8;
    localparam logic [7:0]  GAP_RST = 8'd10;
    localparam logic [12:0] AVG_RST = 13'd256;
    localparam logic [12:0] AVG_MAX = 13'd8191;
    localparam logic [7:0]  EPC_MAX = 8'd255;

    localparam logic REG_ATT = 1'b0;
    localparam logic REG_GAP = 1'b1;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_POP = 1'b1;

    typedef struct packed {
        logic        op;
        logic [15:0] seq_num;
        logic [15:0] packet_handle;
        logic        silence_flag;
    } cmd_t;

    typedef struct packed {
        logic        out_valid;
        logic [15:0] out_handle;
        logic        dropped;
        logic [15:0] dropped_handle;
        logic [4:0]  fill_count;
        logic [12:0] fill_average;
        logic        muted;
    } result_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [15:0] handle;
        logic        silent;
    } slot_t;

endpackage

### rtl/pjb_ram.sv
// ============================================================================
// pjb_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ============================================================================
`timescale 1ns / 1ps

module pjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/packet_jitter_buffer.sv
// ============================================================================
// packet_jitter_buffer: reordering ring of packet slots for playback
// Adds packets by sequence offset from the head, pops them in order.
// ============================================================================
// Usage:
//  - Command channel: present a word on cmd with start high; it is taken at
//    the rising edge where start is high and busy is low. op ADD stores a
//    packet, op POP removes the head slot for playback.
//  - Result channel: one result word per command, shown on result for exactly
//    one cycle with done high. The receiver cannot stall it; busy is already
//    low in that cycle so the next command can be taken at the same edge.
//  - Config: cfg_we/cfg_index/cfg_wdata write attenuation (index 0) and the
//    silence gap limit (index 1); write only while idle.
//  - Sequencing: an add reads the head slot, reads the target slot and
//    writes it back. A pop reads the head slot, walks the in-order packets
//    (up to SLOT_COUNT), then updates the average by a restoring divide,
//    one quotient bit per cycle, skipped in silence or for a silent head
//    packet. The walk reads one slot per cycle from the slot RAM.
//  - Reset: valid bits cleared at once (flops), head 0, average 256, silence
//    state on. No clearing pass; slot RAM contents are qualified by valid.
// ============================================================================
`timescale 1ns / 1ps

module packet_jitter_buffer
    import pjb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result,
    input  logic    cfg_we,
    input  logic    cfg_index,
    input  logic [8:0] cfg_wdata
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int DW    = 23;   // avg * (att - 1) + target
    localparam int SW    = $bits(slot_t);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_A_HEAD = 3'd1;
    localparam logic [2:0] S_A_POS  = 3'd2;
    localparam logic [2:0] S_P_HEAD = 3'd3;
    localparam logic [2:0] S_P_WALK = 3'd4;
    localparam logic [2:0] S_P_MUL  = 3'd5;
    localparam logic [2:0] S_P_DIV  = 3'd6;
    localparam logic [2:0] S_P_FIN  = 3'd7;

    // wrap-around increment/add on slot indexes
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(SLOT_COUNT))
        begin
            s = s - (IDX_W+1)'(SLOT_COUNT);
        end
        return s[IDX_W-1:0];
    endfunction

    // configuration
    logic [8:0] att_reg;
    logic [7:0] gap_reg;

    // block state
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [7:0]            epc_reg, epc_next;
    logic [12:0]           avg_reg, avg_next;
    logic                  sil_reg, sil_next;

    // sequencer
    logic [2:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [IDX_W-1:0] addr_reg, addr_next;      // add target / walk slot
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      first_reg, first_next;
    logic [15:0]      ph_reg, ph_next;
    logic             have_reg, have_next;
    logic             psil_reg, psil_next;
    logic [DW-1:0]    q_reg, q_next;
    logic [8:0]       rem_reg, rem_next;
    logic [4:0]       step_reg, step_next;
    logic [12:0]      navg_reg, navg_next;
    result_t          res_reg, res_next;
    logic             done_reg, done_next;

    // slot RAM
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    slot_t            ram_wdata, ram_rdata;
    logic [SW-1:0]    ram_rbits;

    pjb_ram #(
        .WIDTH (SW),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    assign ram_rdata = slot_t'(ram_rbits);

    // datapath helpers
    logic [8:0]          att_eff;
    logic [16:0]         offset;
    logic [IDX_W-1:0]    pos_calc;
    logic [IDX_W-1:0]    nxt_idx;
    logic [CNT_W-1:0]    cnt_inc;
    logic [CNT_W+7:0]    tgt_wide;
    logic [12:0]         target;
    logic [9:0]          rem_sh;
    logic                q_bit;
    logic [CNT_W+4:0]    cnt_ext;
    logic [21:0]         product;

    assign att_eff  = (att_reg == 9'd0) ? 9'd1 : att_reg;
    assign tgt_wide = {cnt_reg, 8'd0};
    assign target   = (tgt_wide > (CNT_W+8)'(AVG_MAX)) ? AVG_MAX : tgt_wide[12:0];
    assign cnt_ext  = {5'd0, cnt_reg};
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign product  = avg_reg * (att_eff - 9'd1);
    assign rem_sh   = {rem_reg, q_reg[DW-1]};
    assign q_bit    = (rem_sh >= {1'b0, att_eff});

    // offset from the head packet; zero when the head slot is empty
    assign offset   = valid_reg[head_reg] ? ({1'b0, cmd_reg.seq_num} - {1'b0, ram_rdata.seq})
                                          : 17'd0;
    assign pos_calc = idx_add(head_reg, offset[IDX_W-1:0]);
    assign nxt_idx  = idx_add((state_reg == S_P_HEAD) ? head_reg : addr_reg, IDX_W'(1));

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        addr_next  = addr_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        ph_next    = ph_reg;
        have_next  = have_reg;
        psil_next  = psil_reg;
        q_next     = q_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        navg_next  = navg_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        valid_next = valid_reg;
        head_next  = head_reg;
        epc_next   = epc_reg;
        avg_next   = avg_reg;
        sil_next   = sil_reg;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg;
        ram_wdata  = '{seq: cmd_reg.seq_num, handle: cmd_reg.packet_handle,
                       silent: cmd_reg.silence_flag};
        ram_raddr  = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd;
                    state_next = (cmd.op == OP_POP) ? S_P_HEAD : S_A_HEAD;
                end
            end

            S_A_HEAD:
            begin
                if (offset[16])
                begin
                    // late packet: discard the arrival
                    res_next           = '0;
                    res_next.dropped   = 1'b1;
                    res_next.dropped_handle = cmd_reg.packet_handle;
                    done_next          = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    if (offset < 17'(SLOT_COUNT))
                    begin
                        addr_next = pos_calc;
                    end
                    else
                    begin
                        // far ahead: take the head slot, advance head
                        addr_next = head_reg;
                        head_next = idx_add(head_reg, IDX_W'(1));
                    end
                    ram_raddr  = addr_next;
                    state_next = S_A_POS;
                end
            end

            S_A_POS:
            begin
                res_next = '0;
                if (valid_reg[addr_reg])
                begin
                    res_next.dropped        = 1'b1;
                    res_next.dropped_handle = ram_rdata.handle;
                end
                ram_we               = 1'b1;
                valid_next[addr_reg] = 1'b1;
                done_next            = 1'b1;
                state_next           = S_IDLE;
            end

            S_P_HEAD:
            begin
                have_next  = valid_reg[head_reg];
                first_next = ram_rdata.seq;
                ph_next    = valid_reg[head_reg] ? ram_rdata.handle : 16'd0;
                psil_next  = valid_reg[head_reg] && ram_rdata.silent;
                if (!valid_reg[head_reg])
                begin
                    cnt_next   = '0;
                    state_next = S_P_MUL;
                end
                else
                begin
                    cnt_next  = CNT_W'(1);
                    addr_next = nxt_idx;
                    ram_raddr = nxt_idx;
                    state_next = valid_reg[nxt_idx] ? S_P_WALK : S_P_MUL;
                end
            end

            S_P_WALK:
            begin
                if (ram_rdata.seq >= first_reg)
                begin
                    cnt_next  = cnt_inc;
                    addr_next = nxt_idx;
                    ram_raddr = nxt_idx;
                    if ((cnt_inc < CNT_W'(SLOT_COUNT)) && valid_reg[nxt_idx])
                    begin
                        state_next = S_P_WALK;
                    end
                    else
                    begin
                        state_next = S_P_MUL;
                    end
                end
                else
                begin
                    state_next = S_P_MUL;
                end
            end

            S_P_MUL:
            begin
                if (psil_reg || sil_reg)
                begin
                    navg_next  = target;
                    state_next = S_P_FIN;
                end
                else
                begin
                    q_next     = {1'b0, product} + {10'd0, target};
                    rem_next   = '0;
                    step_next  = 5'(DW);
                    state_next = S_P_DIV;
                end
            end

            S_P_DIV:
            begin
                // restoring divide, one quotient bit per cycle
                rem_next  = q_bit ? 9'(rem_sh - {1'b0, att_eff}) : rem_sh[8:0];
                q_next    = {q_reg[DW-2:0], q_bit};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd1)
                begin
                    navg_next  = (q_next > DW'(AVG_MAX)) ? AVG_MAX : q_next[12:0];
                    state_next = S_P_FIN;
                end
            end

            S_P_FIN:
            begin
                valid_next[head_reg] = 1'b0;
                head_next            = idx_add(head_reg, IDX_W'(1));
                if (have_reg)
                begin
                    epc_next = '0;
                end
                else if (epc_reg < EPC_MAX)
                begin
                    epc_next = epc_reg + 8'd1;
                end
                avg_next = navg_reg;
                sil_next = have_reg ? 1'b0 : sil_reg;
                if (epc_next >= gap_reg)
                begin
                    sil_next = 1'b1;
                end
                res_next              = '0;
                res_next.out_valid    = have_reg && !sil_next;
                res_next.out_handle   = (have_reg && !sil_next) ? ph_reg : 16'd0;
                res_next.dropped      = have_reg && sil_next;
                res_next.dropped_handle = (have_reg && sil_next) ? ph_reg : 16'd0;
                res_next.fill_count   = cnt_ext[4:0];
                res_next.fill_average = navg_reg;
                res_next.muted        = sil_next;
                done_next             = 1'b1;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
            head_reg  <= '0;
            epc_reg   <= '0;
            avg_reg   <= AVG_RST;
            sil_reg   <= 1'b1;
            att_reg   <= ATT_RST;
            gap_reg   <= GAP_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            valid_reg <= valid_next;
            head_reg  <= head_next;
            epc_reg   <= epc_next;
            avg_reg   <= avg_next;
            sil_reg   <= sil_next;
            if (cfg_we && (cfg_index == REG_ATT))
            begin
                att_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_GAP))
            begin
                gap_reg <= cfg_wdata[7:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        addr_reg  <= addr_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        ph_reg    <= ph_next;
        have_reg  <= have_next;
        psil_reg  <= psil_next;
        q_reg     <= q_next;
        rem_reg   <= rem_next;
        step_reg  <= step_next;
        navg_reg  <= navg_next;
        res_reg   <= res_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

endmodule

### rtl/pjb_checker.sv
// ============================================================================
// pjb_checker: port-level checks for the packet jitter buffer
// Bound to the top level.
// ============================================================================
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pjb_checker
    import pjb_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `ASSERT_IMP(a_done_after_work, done, $past(busy))
    `ASSERT_NEVER(a_deliver_xor_drop, done && result.out_valid && result.dropped)
    `ASSERT_IMP(a_deliver_unmuted, done && result.out_valid, !result.muted)

endmodule

bind packet_jitter_buffer pjb_checker u_pjb_checker (.*);

### bench/tb_packet_jitter_buffer.sv
// ============================================================================
// tb_packet_jitter_buffer: self-checking bench for the packet jitter buffer
// Drives add/pop words, predicts each result word and compares field by field.
// ============================================================================
`timescale 1ns / 1ps

module tb_packet_jitter_buffer
    import pjb_pkg::*;
();

    localparam int NSLOT = 16;
    localparam longint CYCLE_LIMIT = 2000000;

    logic       clk;
    logic       rst_n;
    logic       start;
    cmd_t       cmd;
    logic       busy;
    logic       done;
    result_t    result;
    logic       cfg_we;
    logic       cfg_index;
    logic [8:0] cfg_wdata;

    packet_jitter_buffer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Mirror of the block state
    logic [8:0]  att_reg;
    logic [7:0]  gap_reg;
    logic        mv_valid [NSLOT];
    logic [15:0] mv_seq [NSLOT];
    logic [15:0] mv_handle [NSLOT];
    logic        mv_silent [NSLOT];
    logic [3:0]  mv_head;
    logic [7:0]  mv_empty_pops;
    logic [12:0] mv_avg;
    logic        mv_silence;

    result_t     pending_results[$];
    int          fail_count;
    longint      cycle_count;
    int          send_idle_pct;
    logic [15:0] seq_base;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void mirror_reset();
        att_reg = ATT_RST;
        gap_reg = GAP_RST;
        for (int i = 0; i < NSLOT; i++)
            mv_valid[i] = 1'b0;
        mv_head = '0;
        mv_empty_pops = '0;
        mv_avg = AVG_RST;
        mv_silence = 1'b1;
    endfunction

    // Predict the result of one word and advance the mirror
    function automatic result_t buffer_step(cmd_t c);
        result_t r;
        int      offset;
        int      pos;
        int      cnt;
        int      p;
        logic    have;
        logic    psil;
        logic [15:0] ph;
        longint  att;
        longint  target;
        longint  a;
        r = '0;
        if (c.op == OP_ADD)
        begin
            offset = 0;
            if (mv_valid[mv_head])
                offset = int'(c.seq_num) - int'(mv_seq[mv_head]);
            if (offset < 0)
            begin
                // late packet is discarded as it arrives
                r.dropped = 1'b1;
                r.dropped_handle = c.packet_handle;
            end
            else
            begin
                if (offset < NSLOT)
                    pos = (mv_head + offset) % NSLOT;
                else
                begin
                    pos = mv_head;
                    mv_head = mv_head + 1'b1;
                end
                if (mv_valid[pos])
                begin
                    r.dropped = 1'b1;
                    r.dropped_handle = mv_handle[pos];
                end
                mv_valid[pos] = 1'b1;
                mv_seq[pos] = c.seq_num;
                mv_handle[pos] = c.packet_handle;
                mv_silent[pos] = c.silence_flag;
            end
        end
        else
        begin
            cnt = 0;
            if (mv_valid[mv_head])
            begin
                while (cnt < NSLOT)
                begin
                    p = (mv_head + cnt) % NSLOT;
                    if (!mv_valid[p] || mv_seq[p] < mv_seq[mv_head])
                        break;
                    cnt++;
                end
            end
            have = mv_valid[mv_head];
            psil = have && mv_silent[mv_head];
            ph = have ? mv_handle[mv_head] : 16'd0;
            att = (att_reg == 0) ? 1 : att_reg;
            target = cnt * 256;
            if (target > AVG_MAX)
                target = AVG_MAX;
            mv_valid[mv_head] = 1'b0;
            mv_head = mv_head + 1'b1;
            if (have)
                mv_empty_pops = '0;
            else if (mv_empty_pops < EPC_MAX)
                mv_empty_pops++;
            if (psil || mv_silence)
                mv_avg = target[12:0];
            else
            begin
                a = (longint'(mv_avg) * (att - 1) + target) / att;
                mv_avg = (a > AVG_MAX) ? AVG_MAX : a[12:0];
            end
            if (have)
                mv_silence = 1'b0;
            if (mv_empty_pops >= gap_reg)
                mv_silence = 1'b1;
            if (have)
            begin
                if (mv_silence)
                begin
                    r.dropped = 1'b1;
                    r.dropped_handle = ph;
                end
                else
                begin
                    r.out_valid = 1'b1;
                    r.out_handle = ph;
                end
            end
            r.fill_count = cnt[4:0];
            r.fill_average = mv_avg;
            r.muted = mv_silence;
        end
        return r;
    endfunction

    // Result checker: the receiver cannot stall, so every done word is taken
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word %h", $time, result);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.out_valid !== want.out_valid)
                    $display("%0t: out_valid exp %h got %h", $time,
                             want.out_valid, result.out_valid);
                if (result.out_handle !== want.out_handle)
                    $display("%0t: out_handle exp %h got %h", $time,
                             want.out_handle, result.out_handle);
                if (result.dropped !== want.dropped)
                    $display("%0t: dropped exp %h got %h", $time,
                             want.dropped, result.dropped);
                if (result.dropped_handle !== want.dropped_handle)
                    $display("%0t: dropped_handle exp %h got %h", $time,
                             want.dropped_handle, result.dropped_handle);
                if (result.fill_count !== want.fill_count)
                    $display("%0t: fill_count exp %0d got %0d", $time,
                             want.fill_count, result.fill_count);
                if (result.fill_average !== want.fill_average)
                    $display("%0t: fill_average exp %0d got %0d", $time,
                             want.fill_average, result.fill_average);
                if (result.muted !== want.muted)
                    $display("%0t: muted exp %h got %h", $time,
                             want.muted, result.muted);
                if (result !== want)
                    fail_count++;
            end
        end
    end

    // Send one word; start stays high until the accepting edge and drops
    // only when the sender idles or the bench waits for the block
    task automatic send_word(cmd_t c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(buffer_step(c));
    endtask

    task automatic add_pkt(logic [15:0] s, logic [15:0] h, logic sil);
        cmd_t c;
        c.op = OP_ADD;
        c.seq_num = s;
        c.packet_handle = h;
        c.silence_flag = sil;
        send_word(c);
    endtask

    // Pop with random don't-care payload so every bit toggles
    task automatic pop_pkt();
        cmd_t c;
        c.op = OP_POP;
        c.seq_num = 16'($urandom);
        c.packet_handle = 16'($urandom);
        c.silence_flag = 1'($urandom);
        send_word(c);
    endtask

    // Drop start, drain outstanding words, then allow the longest pop latency
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_ATT)
            att_reg = val;
        else
            gap_reg = val[7:0];
    endtask

    // Directed: empty pops, in-order fill, reorder, overwrite, late, far ahead
    task automatic test_directed();
        pop_pkt();                              // pop on empty buffer
        add_pkt(16'd100, 16'hFFFF, 1'b0);       // empty head -> head slot
        add_pkt(16'd102, 16'h0002, 1'b0);       // out of order
        add_pkt(16'd101, 16'h0001, 1'b1);
        add_pkt(16'd101, 16'h0011, 1'b0);       // overwrite occupied slot
        add_pkt(16'd99,  16'h0000, 1'b0);       // late
        pop_pkt();
        pop_pkt();
        pop_pkt();
        add_pkt(16'd200, 16'h1234, 1'b1);       // empty head -> head slot; the next word lands far ahead
        add_pkt(16'hFFFF, 16'hABCD, 1'b0);
        add_pkt(16'd0, 16'h5555, 1'b0);
        for (int i = 0; i < 6; i++)
            pop_pkt();
    endtask

    // Mostly near-in-order streams with pops, some noise
    task automatic test_random(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 45)
                pop_pkt();
            else if (k < 85)
            begin
                seq_base = seq_base + 1'b1;
                add_pkt(16'(seq_base + $urandom_range(6) - 3), 16'($urandom),
                        ($urandom_range(9) == 0));
            end
            else if (k < 93)
                add_pkt(16'(seq_base + $urandom_range(40) - 20), 16'($urandom),
                        1'($urandom));
            else
                add_pkt(16'($urandom), 16'($urandom), 1'($urandom));
        end
    endtask

    // Both registers at extremes and mid values, with each idling phase
    task automatic test_settings();
        write_reg(REG_ATT, 9'd1);
        write_reg(REG_GAP, 9'd1);
        send_idle_pct = 0;
        test_random(380);
        write_reg(REG_ATT, 9'd256);
        write_reg(REG_GAP, 9'd255);
        send_idle_pct = 73;
        test_random(380);
        write_reg(REG_ATT, 9'($urandom_range(2, 255)));
        write_reg(REG_GAP, 9'($urandom_range(2, 20)));
        send_idle_pct = 28;
        test_random(380);
        write_reg(REG_ATT, 9'd511);             // wider than the range
        write_reg(REG_GAP, 9'd3);
        send_idle_pct = 0;
        test_random(380);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_wdata = '0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        seq_base = 16'd1000;
        mirror_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_settings();
        wait_idle();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
